### hw/rtl/tpag_pkg.sv
package tpag_pkg;

   // Fixed field widths of the ports and register packing
   localparam int INDEX_BITS        = 32;
   localparam int CSR_DATA_BITS     = 64;
   localparam int CSR_INDEX_BITS    = 3;
   localparam int AXIS_COUNT_BITS   = 3;
   localparam int ORDER_BITS        = 8;
   localparam int ORDER_FIELD_BITS  = 2;
   localparam int EXTENT_FIELD_BITS = 16;
   localparam int STRIDE_FIELD_BITS = 32;

   // Quotient bits resolved by one divider stage
   localparam int STEP_BITS = 4;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NUM_AXES            = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_AXIS_ORDER          = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SOURCE_EXTENTS      = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SOURCE_STRIDES_LOW  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SOURCE_STRIDES_HIGH = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEST_STRIDES_LOW    = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEST_STRIDES_HIGH   = 3'd6;

   localparam logic [AXIS_COUNT_BITS-1:0] NUM_AXES_RESET   = 3'd4;
   localparam logic [ORDER_BITS-1:0]      AXIS_ORDER_RESET = 8'd228;

   localparam int MAX_AXES_DEFAULT     = 4;
   localparam int EXTENT_BITS_DEFAULT  = 16;
   localparam int ADDRESS_BITS_DEFAULT = 32;

endpackage

### hw/rtl/tpag_div_stage.sv
module tpag_div_stage #(
   parameter int MAX_AXES    = tpag_pkg::MAX_AXES_DEFAULT,
   parameter int EXTENT_BITS = tpag_pkg::EXTENT_BITS_DEFAULT,
   parameter int SLOT        = 0,
   parameter bit FIRST       = 1'b0,
   parameter bit LAST        = 1'b0
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    in_valid,
   output logic                                    in_ready,
   input  logic [tpag_pkg::INDEX_BITS-1:0]         in_quot,
   input  logic [EXTENT_BITS-1:0]                  in_rem,
   input  logic [MAX_AXES-1:0][EXTENT_BITS-1:0]    in_coord,
   input  logic                                    in_zero,
   input  logic                                    active,
   input  logic [EXTENT_BITS-1:0]                  divisor,
   output logic                                    out_valid,
   input  logic                                    out_ready,
   output logic [tpag_pkg::INDEX_BITS-1:0]         out_quot,
   output logic [EXTENT_BITS-1:0]                  out_rem,
   output logic [MAX_AXES-1:0][EXTENT_BITS-1:0]    out_coord,
   output logic                                    out_zero
);

   logic                                 valid_ff;
   logic [tpag_pkg::INDEX_BITS-1:0]      quot_ff, quot_in;
   logic [EXTENT_BITS-1:0]               rem_ff, rem_in;
   logic [MAX_AXES-1:0][EXTENT_BITS-1:0] coord_ff, coord_in;
   logic                                 zero_ff, zero_in;
   logic [EXTENT_BITS:0]                 trial;

   assign in_ready = !valid_ff || out_ready;

   // Restoring division, STEP_BITS quotient bits per stage; quotient shifts in at the bottom
   always_comb begin
      rem_in   = FIRST ? '0 : in_rem;
      quot_in  = in_quot;
      trial    = '0;
      for (int j = 0; j < tpag_pkg::STEP_BITS; j++) begin
         trial   = {rem_in, quot_in[tpag_pkg::INDEX_BITS-1]};
         quot_in = {quot_in[tpag_pkg::INDEX_BITS-2:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            trial      = trial - {1'b0, divisor};
            quot_in[0] = 1'b1;
         end
         rem_in = trial[EXTENT_BITS-1:0];
      end
      coord_in = in_coord;
      zero_in  = in_zero;
      if (active) begin
         if (FIRST && divisor == '0) zero_in = 1'b1;
         if (LAST) coord_in[SLOT] = rem_in;
      end else begin
         // unused axis: pass the item through
         rem_in  = in_rem;
         quot_in = in_quot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         quot_ff  <= quot_in;
         rem_ff   <= rem_in;
         coord_ff <= coord_in;
         zero_ff  <= zero_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_quot  = quot_ff;
   assign out_rem   = rem_ff;
   assign out_coord = coord_ff;
   assign out_zero  = zero_ff;

endmodule

### hw/rtl/tpag_addr_calc.sv
module tpag_addr_calc #(
   parameter int MAX_AXES     = tpag_pkg::MAX_AXES_DEFAULT,
   parameter int EXTENT_BITS  = tpag_pkg::EXTENT_BITS_DEFAULT,
   parameter int ADDRESS_BITS = tpag_pkg::ADDRESS_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  logic [MAX_AXES-1:0][EXTENT_BITS-1:0]  in_coord,
   input  logic                                  in_out_of_range,
   input  logic [MAX_AXES-1:0][ADDRESS_BITS-1:0] src_stride,
   input  logic [MAX_AXES-1:0][ADDRESS_BITS-1:0] dst_stride,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output logic [ADDRESS_BITS-1:0]               source_address,
   output logic [ADDRESS_BITS-1:0]               dest_address,
   output logic                                  out_of_range
);

   localparam int PROD_BITS = EXTENT_BITS + ADDRESS_BITS;

   logic                                  mul_valid_ff, sum_valid_ff;
   logic                                  mul_ready, sum_ready;
   logic [MAX_AXES-1:0][ADDRESS_BITS-1:0] src_prod_ff, src_prod_in;
   logic [MAX_AXES-1:0][ADDRESS_BITS-1:0] dst_prod_ff, dst_prod_in;
   logic                                  mul_oor_ff;
   logic [ADDRESS_BITS-1:0]               src_sum_ff, src_sum_in;
   logic [ADDRESS_BITS-1:0]               dst_sum_ff, dst_sum_in;
   logic                                  sum_oor_ff;
   logic [PROD_BITS-1:0]                  src_full, dst_full;

   assign sum_ready = !sum_valid_ff || out_ready;
   assign mul_ready = !mul_valid_ff || sum_ready;
   assign in_ready  = mul_ready;

   always_comb begin
      src_full = '0;
      dst_full = '0;
      for (int d = 0; d < MAX_AXES; d++) begin
         src_full       = PROD_BITS'(in_coord[d]) * PROD_BITS'(src_stride[d]);
         dst_full       = PROD_BITS'(in_coord[d]) * PROD_BITS'(dst_stride[d]);
         src_prod_in[d] = src_full[ADDRESS_BITS-1:0];
         dst_prod_in[d] = dst_full[ADDRESS_BITS-1:0];
      end
   end

   // Sums wrap at the address width; drop to zero for an index at or past the total
   always_comb begin
      src_sum_in = '0;
      dst_sum_in = '0;
      for (int d = 0; d < MAX_AXES; d++) begin
         src_sum_in = src_sum_in + src_prod_ff[d];
         dst_sum_in = dst_sum_in + dst_prod_ff[d];
      end
      if (mul_oor_ff) begin
         src_sum_in = '0;
         dst_sum_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         sum_valid_ff <= 1'b0;
      end else begin
         if (mul_ready) mul_valid_ff <= in_valid;
         if (sum_ready) sum_valid_ff <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && mul_ready) begin
         src_prod_ff <= src_prod_in;
         dst_prod_ff <= dst_prod_in;
         mul_oor_ff  <= in_out_of_range;
      end
      if (mul_valid_ff && sum_ready) begin
         src_sum_ff <= src_sum_in;
         dst_sum_ff <= dst_sum_in;
         sum_oor_ff <= mul_oor_ff;
      end
   end

   assign out_valid      = sum_valid_ff;
   assign source_address = src_sum_ff;
   assign dest_address   = dst_sum_ff;
   assign out_of_range   = sum_oor_ff;

endmodule

### hw/rtl/tensor_permute_address_gen.sv
// Tensor permute address generator: takes one linear output element index per cycle and
// returns the source and destination element offsets of a transpose over up to MAX_AXES
// axes, with out_of_range set (and both addresses zero) for an index at or past the
// element total. Throughput is one item per clock while rsp_ready does not stall the
// pipeline. The index is split into coordinates by a chain of divider stages that each
// resolve four quotient bits, one group of stages per axis, followed by a multiply stage
// and an add stage. Write the registers only while no item is in flight.
module tensor_permute_address_gen #(
   parameter int MAX_AXES     = tpag_pkg::MAX_AXES_DEFAULT,
   parameter int EXTENT_BITS  = tpag_pkg::EXTENT_BITS_DEFAULT,
   parameter int ADDRESS_BITS = tpag_pkg::ADDRESS_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [tpag_pkg::INDEX_BITS-1:0]       req_element_index,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [ADDRESS_BITS-1:0]               rsp_source_address,
   output logic [ADDRESS_BITS-1:0]               rsp_dest_address,
   output logic                                  rsp_out_of_range,
   input  logic                                  csr_write_enable,
   input  logic [tpag_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [tpag_pkg::CSR_DATA_BITS-1:0]    csr_write_data
);

   localparam int STAGES_PER_SLOT = tpag_pkg::INDEX_BITS / tpag_pkg::STEP_BITS;
   localparam int DIV_STAGES      = MAX_AXES * STAGES_PER_SLOT;

   logic [tpag_pkg::AXIS_COUNT_BITS-1:0] num_axes_ff;
   logic [tpag_pkg::ORDER_BITS-1:0]      axis_order_ff;
   logic [tpag_pkg::CSR_DATA_BITS-1:0]   source_extents_ff;
   logic [tpag_pkg::CSR_DATA_BITS-1:0]   source_strides_low_ff, source_strides_high_ff;
   logic [tpag_pkg::CSR_DATA_BITS-1:0]   dest_strides_low_ff, dest_strides_high_ff;

   logic [tpag_pkg::AXIS_COUNT_BITS-1:0]             axes_used;
   logic [MAX_AXES-1:0]                              slot_active;
   logic [MAX_AXES-1:0][tpag_pkg::ORDER_FIELD_BITS-1:0] order_sel;
   logic [MAX_AXES-1:0][EXTENT_BITS-1:0]             ext_slot;
   logic [MAX_AXES-1:0][ADDRESS_BITS-1:0]            src_stride, dst_stride;
   logic [tpag_pkg::CSR_DATA_BITS-1:0]               src_word, dst_word;

   logic                                 div_valid [0:DIV_STAGES];
   logic                                 div_ready [0:DIV_STAGES];
   logic [tpag_pkg::INDEX_BITS-1:0]      div_quot  [0:DIV_STAGES];
   logic [EXTENT_BITS-1:0]               div_rem   [0:DIV_STAGES];
   logic [MAX_AXES-1:0][EXTENT_BITS-1:0] div_coord [0:DIV_STAGES];
   logic                                 div_zero  [0:DIV_STAGES];
   logic                                 final_oor;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_axes_ff            <= tpag_pkg::NUM_AXES_RESET;
         axis_order_ff          <= tpag_pkg::AXIS_ORDER_RESET;
         source_extents_ff      <= '0;
         source_strides_low_ff  <= '0;
         source_strides_high_ff <= '0;
         dest_strides_low_ff    <= '0;
         dest_strides_high_ff   <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            tpag_pkg::CSR_NUM_AXES: begin
               num_axes_ff <= csr_write_data[tpag_pkg::AXIS_COUNT_BITS-1:0];
            end
            tpag_pkg::CSR_AXIS_ORDER: begin
               axis_order_ff <= csr_write_data[tpag_pkg::ORDER_BITS-1:0];
            end
            tpag_pkg::CSR_SOURCE_EXTENTS:      source_extents_ff      <= csr_write_data;
            tpag_pkg::CSR_SOURCE_STRIDES_LOW:  source_strides_low_ff  <= csr_write_data;
            tpag_pkg::CSR_SOURCE_STRIDES_HIGH: source_strides_high_ff <= csr_write_data;
            tpag_pkg::CSR_DEST_STRIDES_LOW:    dest_strides_low_ff    <= csr_write_data;
            tpag_pkg::CSR_DEST_STRIDES_HIGH:   dest_strides_high_ff   <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Clamp the axis count and look up extents and strides per output axis
   always_comb begin
      if (num_axes_ff == '0) begin
         axes_used = tpag_pkg::AXIS_COUNT_BITS'(1);
      end else if (num_axes_ff > tpag_pkg::AXIS_COUNT_BITS'(MAX_AXES)) begin
         axes_used = tpag_pkg::AXIS_COUNT_BITS'(MAX_AXES);
      end else begin
         axes_used = num_axes_ff;
      end
      src_word = '0;
      dst_word = '0;
      for (int d = 0; d < MAX_AXES; d++) begin
         slot_active[d] = tpag_pkg::AXIS_COUNT_BITS'(d) < axes_used;
         order_sel[d]   = axis_order_ff[tpag_pkg::ORDER_FIELD_BITS*d +: tpag_pkg::ORDER_FIELD_BITS];
         ext_slot[d]    = source_extents_ff[tpag_pkg::EXTENT_FIELD_BITS*order_sel[d] +:
                                            EXTENT_BITS];
         src_word       = order_sel[d][1] ? source_strides_high_ff : source_strides_low_ff;
         src_stride[d]  = src_word[tpag_pkg::STRIDE_FIELD_BITS*order_sel[d][0] +: ADDRESS_BITS];
         dst_word       = (d >= 2) ? dest_strides_high_ff : dest_strides_low_ff;
         dst_stride[d]  = dst_word[tpag_pkg::STRIDE_FIELD_BITS*(d % 2) +: ADDRESS_BITS];
      end
   end

   assign div_valid[0] = req_valid;
   assign req_ready    = div_ready[0];
   assign div_quot[0]  = req_element_index;
   assign div_rem[0]   = '0;
   assign div_coord[0] = '0;
   assign div_zero[0]  = 1'b0;

   // Last axis divides first; each axis gets STAGES_PER_SLOT stages
   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
      localparam int SLOT_ID = MAX_AXES - 1 - s / STAGES_PER_SLOT;
      tpag_div_stage #(
         .MAX_AXES    (MAX_AXES),
         .EXTENT_BITS (EXTENT_BITS),
         .SLOT        (SLOT_ID),
         .FIRST       ((s % STAGES_PER_SLOT) == 0),
         .LAST        ((s % STAGES_PER_SLOT) == STAGES_PER_SLOT - 1)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (div_valid[s]),
         .in_ready  (div_ready[s]),
         .in_quot   (div_quot[s]),
         .in_rem    (div_rem[s]),
         .in_coord  (div_coord[s]),
         .in_zero   (div_zero[s]),
         .active    (slot_active[SLOT_ID]),
         .divisor   (ext_slot[SLOT_ID]),
         .out_valid (div_valid[s+1]),
         .out_ready (div_ready[s+1]),
         .out_quot  (div_quot[s+1]),
         .out_rem   (div_rem[s+1]),
         .out_coord (div_coord[s+1]),
         .out_zero  (div_zero[s+1])
      );
   end

   // A quotient left over after all axes means the index reached the total
   assign final_oor = div_zero[DIV_STAGES] || (div_quot[DIV_STAGES] != '0);

   tpag_addr_calc #(
      .MAX_AXES     (MAX_AXES),
      .EXTENT_BITS  (EXTENT_BITS),
      .ADDRESS_BITS (ADDRESS_BITS)
   ) u_addr (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (div_valid[DIV_STAGES]),
      .in_ready        (div_ready[DIV_STAGES]),
      .in_coord        (div_coord[DIV_STAGES]),
      .in_out_of_range (final_oor),
      .src_stride      (src_stride),
      .dst_stride      (dst_stride),
      .out_valid       (rsp_valid),
      .out_ready       (rsp_ready),
      .source_address  (rsp_source_address),
      .dest_address    (rsp_dest_address),
      .out_of_range    (rsp_out_of_range)
   );

`ifndef ASSERT_OFF
   a_oor_zero_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_range |-> rsp_source_address == '0 && rsp_dest_address == '0)
      else $error("out-of-range item with nonzero address");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without a blocked result");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> div_valid[1])
      else $error("accepted item missing from first stage");
`endif

endmodule
